[sv/dhcp_pkg.sv]
// Shared constants, codes and tables for the DHCP byte parser.
`default_nettype none

package dhcp_pkg;

  // Packet geometry
  localparam int MAX_PACKET_BYTES_DEF = 2048;
  localparam int OFFSET_W             = 12;
  localparam int HDR_LEN              = 236;
  localparam int COOKIE_END           = 240;
  localparam int NUM_FIELDS           = 14;
  localparam int LAST_NUMERIC         = 10;

  // Output region codes
  localparam logic [2:0] REG_HEADER = 3'd0;
  localparam logic [2:0] REG_COOKIE = 3'd1;
  localparam logic [2:0] REG_CODE   = 3'd2;
  localparam logic [2:0] REG_LEN    = 3'd3;
  localparam logic [2:0] REG_DATA   = 3'd4;
  localparam logic [2:0] REG_SKIP   = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TRUNC    = 2'd1;
  localparam logic [1:0] ERR_OVERSIZE = 2'd2;

  // Option codes that are single-byte skips
  localparam logic [7:0] OPT_PAD = 8'd0;
  localparam logic [7:0] OPT_END = 8'd255;

  // Header field layout: op htype hlen hops xid secs flags ciaddr yiaddr
  // siaddr giaddr chaddr sname file
  typedef logic [7:0] fld_arr_t [NUM_FIELDS];

  localparam fld_arr_t FLD_START = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd10, 8'd12, 8'd16, 8'd20,
    8'd24, 8'd28, 8'd44, 8'd108
  };
  localparam fld_arr_t FLD_SIZE = '{
    8'd1, 8'd1, 8'd1, 8'd1, 8'd4, 8'd2, 8'd2, 8'd4, 8'd4, 8'd4,
    8'd4, 8'd16, 8'd64, 8'd128
  };

  // One labeled output word
  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  region;
    logic [3:0]  header_field;
    logic [7:0]  byte_in_field;
    logic [31:0] field_value;
    logic        field_done;
    logic [7:0]  option_code;
    logic        option_done;
    logic        packet_end;
    logic [1:0]  error_code;
  } label_t;

endpackage

`default_nettype wire

[sv/dhcp_ifs.sv]
// Valid/ready channel interfaces for raw message bytes and labeled bytes.
`default_nettype none

interface dhcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface dhcp_label_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [2:0]  region;
  logic [3:0]  header_field;
  logic [7:0]  byte_in_field;
  logic [31:0] field_value;
  logic        field_done;
  logic [7:0]  option_code;
  logic        option_done;
  logic        packet_end;
  logic [1:0]  error_code;

  modport source(
    output valid, byte_out, region, header_field, byte_in_field, field_value,
           field_done, option_code, option_done, packet_end, error_code,
    input  ready
  );
  modport sink(
    input  valid, byte_out, region, header_field, byte_in_field, field_value,
           field_done, option_code, option_done, packet_end, error_code,
    output ready
  );
endinterface

`default_nettype wire

[sv/dhcp_packet_byte_parser.sv]
// DHCP message byte labeler: input register, label logic, result register.
//
// Usage:
//   byte_in   : one message byte per word (data_byte) with last_byte set on
//               the final byte of a message. Accepted when valid && ready.
//   label_out : one labeled word per input byte, in order: region, header
//               field index and position, big-endian value of numeric header
//               fields, option code, field/option completion, packet end
//               copy and error code (truncated or oversize).
//   A byte taken into the input register moves to the result register, which
//   drives label_out, as soon as the result register is free.
//   Throughput is one byte per cycle while label_out.ready is high; the parse
//   state (offset, phase, option counters, value accumulator) is updated in
//   one pass as a byte moves from the input register to the result register.
//   rst (synchronous, active high) empties both registers and returns the
//   parser to the start of a message. After a byte with last_byte set the
//   parser also returns to the start of a message.
//   When the receiver holds ready low the result register holds its word;
//   one more byte is still taken into the input register, after which
//   byte_in.ready drops until the result word is taken.
`default_nettype none

module dhcp_packet_byte_parser
  import dhcp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input wire logic      clk,
  input wire logic      rst,
  dhcp_byte_if.sink     byte_in,
  dhcp_label_if.source  label_out
);

  // Parse phase codes
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_COOKIE = 3'd1;
  localparam logic [2:0] PH_CODE   = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};
  localparam logic [OFFSET_W-1:0] OFS_LIMIT  = OFFSET_W'(MAX_PACKET_BYTES);
  localparam logic [OFFSET_W-1:0] OFS_HDR    = OFFSET_W'(HDR_LEN);
  localparam logic [OFFSET_W-1:0] OFS_COOKIE = OFFSET_W'(COOKIE_END);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Result register
  logic   out_valid;
  label_t lbl;
  label_t lbl_next;

  // Parse state
  logic [OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic [2:0]          parse_phase, parse_phase_next;
  logic [7:0]          option_remaining, option_remaining_next;
  logic [7:0]          current_code, current_code_next;
  logic [7:0]          data_index, data_index_next;
  logic [31:0]         value_accumulator, value_accumulator_next;

  logic       advance;
  logic       trunc;
  logic [3:0] fidx;
  logic [7:0] off8;
  logic [7:0] pos;
  logic [7:0] rem_dec;

  assign advance       = s1_valid && (!out_valid || label_out.ready);
  assign byte_in.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_in.ready) begin
      s1_valid <= byte_in.valid;
    end
    if (byte_in.valid && byte_in.ready) begin
      s1_byte <= byte_in.data_byte;
      s1_last <= byte_in.last_byte;
    end
  end

  // Header field lookup from the byte offset
  assign off8 = byte_offset[7:0];
  always_comb begin
    fidx = 4'd0;
    for (int i = 1; i < NUM_FIELDS; i++) begin
      if (off8 >= FLD_START[i]) fidx = 4'(i);
    end
  end
  assign pos     = off8 - FLD_START[fidx];
  assign rem_dec = option_remaining - 8'd1;

  // Label and next state for the byte in the input register
  always_comb begin
    lbl_next                 = '0;
    lbl_next.byte_out        = s1_byte;
    lbl_next.packet_end      = s1_last;
    trunc                    = 1'b0;
    parse_phase_next         = parse_phase;
    option_remaining_next    = option_remaining;
    current_code_next        = current_code;
    data_index_next          = data_index;
    value_accumulator_next   = value_accumulator;

    if (parse_phase == PH_HEADER && byte_offset < OFS_HDR) begin
      lbl_next.region        = REG_HEADER;
      lbl_next.header_field  = fidx;
      lbl_next.byte_in_field = pos;
      if (fidx <= 4'(LAST_NUMERIC)) begin
        value_accumulator_next = (pos == 8'd0) ? {24'd0, s1_byte}
                                               : {value_accumulator[23:0], s1_byte};
        lbl_next.field_value   = value_accumulator_next;
      end else begin
        value_accumulator_next = '0;
      end
      lbl_next.field_done = ((pos + 8'd1) == FLD_SIZE[fidx]);
      trunc = s1_last;
      if (byte_offset == OFS_HDR - 1'b1) parse_phase_next = PH_COOKIE;
    end else if (parse_phase == PH_HEADER || parse_phase == PH_COOKIE) begin
      lbl_next.region = REG_COOKIE;
      if (byte_offset >= OFS_HDR && byte_offset < OFS_COOKIE) begin
        lbl_next.byte_in_field = 8'(byte_offset - OFS_HDR);
      end
      trunc = s1_last && (byte_offset < OFS_COOKIE - 1'b1);
      parse_phase_next = (byte_offset >= OFS_COOKIE - 1'b1) ? PH_CODE : PH_COOKIE;
    end else if (parse_phase == PH_LEN) begin
      lbl_next.region      = REG_LEN;
      lbl_next.option_code = current_code;
      if (s1_byte == 8'd0) begin
        lbl_next.option_done = 1'b1;
        parse_phase_next     = PH_CODE;
      end else begin
        option_remaining_next = s1_byte;
        data_index_next       = 8'd0;
        parse_phase_next      = PH_DATA;
        trunc                 = s1_last;
      end
    end else if (parse_phase == PH_DATA) begin
      lbl_next.region        = REG_DATA;
      lbl_next.option_code   = current_code;
      lbl_next.byte_in_field = data_index;
      data_index_next        = data_index + 8'd1;
      option_remaining_next  = rem_dec;
      if (rem_dec == 8'd0) begin
        lbl_next.option_done = 1'b1;
        parse_phase_next     = PH_CODE;
      end else begin
        trunc = s1_last;
      end
    end else begin
      lbl_next.option_code = s1_byte;
      if (s1_byte == OPT_PAD || s1_byte == OPT_END) begin
        lbl_next.region = REG_SKIP;
      end else begin
        lbl_next.region   = REG_CODE;
        current_code_next = s1_byte;
        parse_phase_next  = PH_LEN;
        trunc             = s1_last;
      end
    end

    // Oversize wins over truncation
    if (byte_offset >= OFS_LIMIT) begin
      lbl_next.error_code = ERR_OVERSIZE;
    end else if (trunc) begin
      lbl_next.error_code = ERR_TRUNC;
    end else begin
      lbl_next.error_code = ERR_NONE;
    end

    byte_offset_next = (byte_offset == OFFSET_MAX) ? byte_offset
                                                   : byte_offset + 1'b1;

    // End of message: start over
    if (s1_last) begin
      byte_offset_next       = '0;
      parse_phase_next       = PH_HEADER;
      option_remaining_next  = '0;
      current_code_next      = '0;
      data_index_next        = '0;
      value_accumulator_next = '0;
    end
  end

  // Parse state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      parse_phase       <= PH_HEADER;
      option_remaining  <= '0;
      current_code      <= '0;
      data_index        <= '0;
      value_accumulator <= '0;
    end else if (advance) begin
      byte_offset       <= byte_offset_next;
      parse_phase       <= parse_phase_next;
      option_remaining  <= option_remaining_next;
      current_code      <= current_code_next;
      data_index        <= data_index_next;
      value_accumulator <= value_accumulator_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (label_out.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) lbl <= lbl_next;
  end

  assign label_out.valid         = out_valid;
  assign label_out.byte_out      = lbl.byte_out;
  assign label_out.region        = lbl.region;
  assign label_out.header_field  = lbl.header_field;
  assign label_out.byte_in_field = lbl.byte_in_field;
  assign label_out.field_value   = lbl.field_value;
  assign label_out.field_done    = lbl.field_done;
  assign label_out.option_code   = lbl.option_code;
  assign label_out.option_done   = lbl.option_done;
  assign label_out.packet_end    = lbl.packet_end;
  assign label_out.error_code    = lbl.error_code;

  // Checks
  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> byte_offset == '0 && parse_phase == PH_HEADER &&
                           option_remaining == '0 && value_accumulator == '0)
    else $error("parser did not restart after last byte");

  a_field_done_header: assert property (@(posedge clk) disable iff (rst)
    label_out.valid && label_out.field_done |-> label_out.region == REG_HEADER)
    else $error("field_done outside header");

  a_option_done_region: assert property (@(posedge clk) disable iff (rst)
    label_out.valid && label_out.option_done |->
      label_out.region == REG_LEN || label_out.region == REG_DATA)
    else $error("option_done outside length or data");

  a_options_after_cookie: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_CODE || parse_phase == PH_LEN || parse_phase == PH_DATA
      |-> byte_offset >= OFS_COOKIE)
    else $error("option phase before end of cookie");

  a_data_outstanding: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DATA |-> option_remaining != 8'd0)
    else $error("data phase with no bytes outstanding");

endmodule

`default_nettype wire
